### sv/rfpwd_pkg.sv
// Shared types and constants for the pulse-width remote decoder.
// No dependencies; imported by every module of the block.
package rfpwd_pkg;

  localparam int FRAME_BITS  = 24;
  localparam int CODE_W      = 24;
  localparam int WIDTH_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CNT_W       = $clog2(FRAME_BITS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WIDTH_W-1:0] START_LO_RST = WIDTH_W'(1400);
  localparam logic [WIDTH_W-1:0] START_HI_RST = WIDTH_W'(1500);
  localparam logic [WIDTH_W-1:0] LONG_LO_RST  = WIDTH_W'(580);
  localparam logic [WIDTH_W-1:0] LONG_HI_RST  = WIDTH_W'(680);
  localparam logic [WIDTH_W-1:0] SHORT_LO_RST = WIDTH_W'(150);
  localparam logic [WIDTH_W-1:0] SHORT_HI_RST = WIDTH_W'(250);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LO = 3'd0,
    CFG_START_HI = 3'd1,
    CFG_LONG_LO  = 3'd2,
    CFG_LONG_HI  = 3'd3,
    CFG_SHORT_LO = 3'd4,
    CFG_SHORT_HI = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_CHK0 = 2'd2,
    PH_CHK1 = 2'd3
  } phase_e;

  // One classified edge or timeout, as queued between front and back.
  typedef struct packed {
    logic timeout;
    logic level;
    logic in_start;
    logic in_long;
    logic in_short;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### sv/rfpwd_front.sv
// Front end: window registers and the strict window compares.
// Depends on rfpwd_pkg.
module rfpwd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rfpwd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rfpwd_pkg::WIDTH_W-1:0]   cfg_wdata_i,
  input  logic                            op_i,
  input  logic                            line_level_i,
  input  logic [rfpwd_pkg::WIDTH_W-1:0]   pulse_width_i,
  output rfpwd_pkg::item_t                item_o
);
  import rfpwd_pkg::*;

  logic [WIDTH_W-1:0] start_lo_q, start_hi_q, long_lo_q, long_hi_q;
  logic [WIDTH_W-1:0] short_lo_q, short_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_lo_q <= START_LO_RST;
      start_hi_q <= START_HI_RST;
      long_lo_q  <= LONG_LO_RST;
      long_hi_q  <= LONG_HI_RST;
      short_lo_q <= SHORT_LO_RST;
      short_hi_q <= SHORT_HI_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_LO: start_lo_q <= cfg_wdata_i;
        CFG_START_HI: start_hi_q <= cfg_wdata_i;
        CFG_LONG_LO:  long_lo_q  <= cfg_wdata_i;
        CFG_LONG_HI:  long_hi_q  <= cfg_wdata_i;
        CFG_SHORT_LO: short_lo_q <= cfg_wdata_i;
        CFG_SHORT_HI: short_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Both bounds exclusive.
  always_comb begin
    item_o.timeout  = op_i;
    item_o.level    = line_level_i;
    item_o.in_start = (pulse_width_i > start_lo_q) && (pulse_width_i < start_hi_q);
    item_o.in_long  = (pulse_width_i > long_lo_q)  && (pulse_width_i < long_hi_q);
    item_o.in_short = (pulse_width_i > short_lo_q) && (pulse_width_i < short_hi_q);
  end

endmodule

### sv/rfpwd_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on rfpwd_pkg.
module rfpwd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rfpwd_pkg::item_t item_i,
  input  logic             pop_i,
  output rfpwd_pkg::item_t item_o,
  output rfpwd_pkg::qstat_t stat_o
);
  import rfpwd_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  always_comb begin
    stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
    stat_o.empty = (cnt_q == '0);
    do_push      = push_i && !stat_o.full;
    do_pop       = pop_i && !stat_o.empty;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    cnt_d        = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
    item_o = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### sv/rfpwd_back.sv
// Back end: frame state machine, shift register, bit counter and result register.
// Depends on rfpwd_pkg.
module rfpwd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rfpwd_pkg::qstat_t            stat_i,
  input  rfpwd_pkg::item_t             item_i,
  output logic                         pop_o,
  output logic                         emit_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rfpwd_pkg::CODE_W-1:0] code_o
);
  import rfpwd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CODE_W-1:0] shift_q, shift_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic              out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;

  always_comb begin
    // Take an item only while the result register is free or draining.
    pop_o       = !stat_i.empty && (!out_valid_q || out_ready_i);
    phase_d     = phase_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    emit_o      = 1'b0;
    code_d      = code_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (pop_o) begin
      if (item_i.timeout) begin
        phase_d = PH_IDLE;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (item_i.level && item_i.in_start) begin
              shift_d = '0;
              cnt_d   = '0;
              phase_d = PH_RECV;
            end
          end
          PH_RECV: begin
            if (!item_i.level) begin
              priority if (item_i.in_short) begin
                shift_d = {shift_q[CODE_W-2:0], 1'b0};
                cnt_d   = cnt_q + 1'b1;
                phase_d = PH_CHK0;
              end else if (item_i.in_long) begin
                shift_d = {shift_q[CODE_W-2:0], 1'b1};
                cnt_d   = cnt_q + 1'b1;
                phase_d = PH_CHK1;
              end else begin
                phase_d = PH_IDLE;
              end
            end
          end
          PH_CHK0: begin
            if (item_i.level) begin
              phase_d = item_i.in_long ? PH_RECV : PH_IDLE;
            end
          end
          PH_CHK1: begin
            if (item_i.level) begin
              phase_d = item_i.in_short ? PH_RECV : PH_IDLE;
            end
          end
          default: phase_d = PH_IDLE;
        endcase

        // Frame complete: hand the code over and drop back to idle.
        if (cnt_d == CNT_W'(FRAME_BITS)) begin
          emit_o      = 1'b1;
          code_d      = shift_d;
          cnt_d       = '0;
          phase_d     = PH_IDLE;
          out_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      shift_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

endmodule

### sv/rf_remote_pulse_width_decoder.sv
// Top level of the pulse-width remote frame decoder.
// Depends on rfpwd_pkg, rfpwd_front, rfpwd_queue and rfpwd_back.
//
// Decoder for pulse-width-coded remote frames. Each input beat is either an
// edge capture (op_i low: width of the pulse just ended, line level after the
// edge) or a timer timeout (op_i high), which forces the decoder idle. A low
// pulse inside the start window opens a frame; short high then long low gives
// a 0, long high then short low gives a 1, and any width outside its window
// aborts the frame. After 24 bits the code leaves on the output channel, the
// first received bit in the most significant place. Window bounds are
// exclusive and live in six 16-bit registers (index 0..5: start low/high,
// long low/high, short low/high); writes to other indices are dropped. Write
// them only while no beat is in flight. The block takes one beat per clock
// cycle while codes are taken: the front classifies a width in the accepting
// cycle, pushes it into a two-entry queue, and the back state machine
// retires one queued beat per cycle unless a result waits untaken. The beat
// that completes a frame is queued, then retired by the back, which registers
// its code for output; while it waits, input flows until the queue fills.
module rf_remote_pulse_width_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [rfpwd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rfpwd_pkg::WIDTH_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic                            line_level_i,
  input  logic [rfpwd_pkg::WIDTH_W-1:0]   pulse_width_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rfpwd_pkg::CODE_W-1:0]    code_o
);
  import rfpwd_pkg::*;

  item_t  front_item, queue_item;
  qstat_t qstat;
  logic   push, pop, emit;

  // Accept whenever the queue has room.
  assign in_ready_o = !qstat.full;
  assign push       = in_valid_i && in_ready_o;

  rfpwd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .line_level_i  (line_level_i),
    .pulse_width_i (pulse_width_i),
    .item_o        (front_item)
  );

  rfpwd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (qstat)
  );

  rfpwd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (qstat),
    .item_i      (queue_item),
    .pop_o       (pop),
    .emit_o      (emit),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_o      (code_o)
  );

  // A timeout never produces a code.
  a_no_emit_on_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !queue_item.timeout)
    else $error("code emitted on a timeout beat");

  // The back only retires a beat while the result register can take a code.
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!out_valid_o || out_ready_i) && !qstat.empty)
    else $error("queue popped with no room or no entry");

  // An emitted code shows up as a valid result on the next edge.
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o)
    else $error("emitted code not presented");

  // A full queue with a stalled output cannot drain, so input stays blocked.
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full && out_valid_o && !out_ready_i |=> !in_ready_o)
    else $error("queue lost an entry while stalled");

endmodule
